@@ hw/rtl/spr_pkg.sv @@
`timescale 1ns / 1ps
// spr_pkg: shared types and constants for the stream pattern replace block.
// No dependencies; every other file takes names from here by scope.
package spr_pkg;

    localparam int WIN_DEPTH   = 16;   // pending-byte window entries
    localparam int MAX_PATTERN = 16;   // longest pattern in bytes
    localparam int MAX_REPLACE = 16;   // longest replacement in bytes
    localparam int QDEPTH      = 4;    // descriptor queue entries
    localparam int QAW         = 2;    // queue pointer width
    localparam int CFG_AW      = 6;    // APB byte address width
    localparam int CFG_DW      = 64;   // APB data width

    typedef struct packed {
        logic [7:0] data_byte;
        logic       string_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       output_end;
    } out_item_t;

    typedef enum logic [2:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_PATTERN_LEN  = 3'd2,
        REG_REPLACE_LOW  = 3'd3,
        REG_REPLACE_HIGH = 3'd4,
        REG_REPLACE_LEN  = 3'd5
    } reg_idx_t;

    // What the back end does with one queued item
    typedef enum logic [1:0] {
        DESC_WIN   = 2'd0,   // emit oldest window bytes from the snapshot
        DESC_REPL  = 2'd1,   // emit the replacement string
        DESC_EMPTY = 2'd2    // empty end marker
    } desc_kind_t;

    typedef struct packed {
        logic [MAX_PATTERN-1:0][7:0] pattern;
        logic [4:0]                  plen;     // clamped length
        logic [MAX_REPLACE-1:0][7:0] repl;
        logic [4:0]                  rlen;     // clamped length
    } cfg_t;

    typedef struct packed {
        desc_kind_t                kind;
        logic [WIN_DEPTH-1:0][7:0] snap;     // window, newest byte at entry 0
        logic [3:0]                start;    // snapshot entry of first byte out
        logic [4:0]                num;      // results to emit, 1 to 16
        logic                      str_end;  // item closed the string
    } desc_t;

endpackage

@@ hw/rtl/spr_cfg.sv @@
`timescale 1ns / 1ps
// spr_cfg: APB register bank for pattern and replacement settings.
// Depends on spr_pkg.
module spr_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spr_pkg::CFG_AW-1:0]  paddr,
    input  logic [spr_pkg::CFG_DW-1:0]  pwdata,
    output logic [spr_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    output spr_pkg::cfg_t               cfg
);

    logic [63:0]       pat_lo_reg;
    logic [63:0]       pat_hi_reg;
    logic [4:0]        pat_len_reg;
    logic [63:0]       rep_lo_reg;
    logic [63:0]       rep_hi_reg;
    logic [4:0]        rep_len_reg;
    logic              wr_en;
    spr_pkg::reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = spr_pkg::reg_idx_t'(paddr[spr_pkg::CFG_AW-1:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo_reg  <= '0;
            pat_hi_reg  <= '0;
            pat_len_reg <= '0;
            rep_lo_reg  <= '0;
            rep_hi_reg  <= '0;
            rep_len_reg <= '0;
        end else if (wr_en) begin
            unique case (idx)
                spr_pkg::REG_PATTERN_LOW:  pat_lo_reg  <= pwdata;
                spr_pkg::REG_PATTERN_HIGH: pat_hi_reg  <= pwdata;
                spr_pkg::REG_PATTERN_LEN:  pat_len_reg <= pwdata[4:0];
                spr_pkg::REG_REPLACE_LOW:  rep_lo_reg  <= pwdata;
                spr_pkg::REG_REPLACE_HIGH: rep_hi_reg  <= pwdata;
                spr_pkg::REG_REPLACE_LEN:  rep_len_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            spr_pkg::REG_PATTERN_LOW:  prdata = pat_lo_reg;
            spr_pkg::REG_PATTERN_HIGH: prdata = pat_hi_reg;
            spr_pkg::REG_PATTERN_LEN:  prdata = {59'd0, pat_len_reg};
            spr_pkg::REG_REPLACE_LOW:  prdata = rep_lo_reg;
            spr_pkg::REG_REPLACE_HIGH: prdata = rep_hi_reg;
            spr_pkg::REG_REPLACE_LEN:  prdata = {59'd0, rep_len_reg};
            default:                   prdata = '0;
        endcase
    end

    // Oversized lengths saturate at the maximum
    always_comb begin
        cfg.pattern = {pat_hi_reg, pat_lo_reg};
        cfg.repl    = {rep_hi_reg, rep_lo_reg};
        cfg.plen    = (pat_len_reg > 5'(spr_pkg::MAX_PATTERN)) ?
                      5'(spr_pkg::MAX_PATTERN) : pat_len_reg;
        cfg.rlen    = (rep_len_reg > 5'(spr_pkg::MAX_REPLACE)) ?
                      5'(spr_pkg::MAX_REPLACE) : rep_len_reg;
    end

endmodule

@@ hw/rtl/spr_front.sv @@
`timescale 1ns / 1ps
// spr_front: takes input items, keeps the pending window and classifies each
// item into at most one queue descriptor. Depends on spr_pkg.
module spr_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  spr_pkg::in_item_t s_item,
    input  spr_pkg::cfg_t     cfg,
    output logic              q_wr_valid,
    output spr_pkg::desc_t    q_wr_data,
    input  logic              q_wr_ready
);

    logic [spr_pkg::WIN_DEPTH-1:0][7:0] hist_reg;
    logic [spr_pkg::WIN_DEPTH-1:0][7:0] hist_next;
    logic [3:0]                         count_reg;
    logic [3:0]                         count_next;
    logic [4:0]                         cnt1;
    logic [spr_pkg::WIN_DEPTH:0]        cmp;
    logic [4:0]                         lmax;
    logic [4:0]                         nbytes;
    logic                               full_match;
    logic                               accept;
    logic                               emit;
    logic                               last;

    assign s_ready = q_wr_ready;
    assign accept  = s_valid && s_ready;
    assign last    = s_item.string_end;

    // Window as a shift line: entry 0 newest, entry count oldest
    assign hist_next = {hist_reg[spr_pkg::WIN_DEPTH-2:0], s_item.data_byte};
    assign cnt1      = {1'b0, count_reg} + 5'd1;

    // cmp[l]: newest l bytes equal the first l pattern bytes
    always_comb begin
        logic m;
        cmp[0] = 1'b1;
        for (int l = 1; l <= spr_pkg::WIN_DEPTH; l++) begin
            m = 1'b1;
            for (int i = 0; i < l; i++) begin
                m = m & (hist_next[l-1-i] == cfg.pattern[i]);
            end
            cmp[l] = m;
        end
    end

    // Longest surviving suffix that is a proper prefix of the pattern
    always_comb begin
        lmax = 5'd0;
        for (int l = 1; l <= spr_pkg::WIN_DEPTH; l++) begin
            if ((5'(l) <= cnt1) && (5'(l) < cfg.plen) && cmp[l]) begin
                lmax = 5'(l);
            end
        end
    end

    assign full_match = (cfg.plen != 5'd0) && (cnt1 == cfg.plen) && cmp[cfg.plen];
    assign nbytes     = last ? cnt1 : (cnt1 - lmax);

    always_comb begin
        q_wr_data.snap    = hist_next;
        q_wr_data.start   = count_reg;
        q_wr_data.str_end = last;
        q_wr_data.kind    = spr_pkg::DESC_WIN;
        q_wr_data.num     = nbytes;
        emit              = 1'b0;
        count_next        = last ? 4'd0 : lmax[3:0];
        if (full_match) begin
            count_next = 4'd0;
            if (cfg.rlen != 5'd0) begin
                q_wr_data.kind = spr_pkg::DESC_REPL;
                q_wr_data.num  = cfg.rlen;
                emit           = 1'b1;
            end else if (last) begin
                q_wr_data.kind = spr_pkg::DESC_EMPTY;
                q_wr_data.num  = 5'd1;
                emit           = 1'b1;
            end
        end else if (nbytes != 5'd0) begin
            emit = 1'b1;
        end else if (last) begin
            q_wr_data.kind = spr_pkg::DESC_EMPTY;
            q_wr_data.num  = 5'd1;
            emit           = 1'b1;
        end
    end

    assign q_wr_valid = accept && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (accept) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hist_reg <= hist_next;
        end
    end

endmodule

@@ hw/rtl/spr_queue.sv @@
`timescale 1ns / 1ps
// spr_queue: short descriptor FIFO between the front and back ends.
// Depends on spr_pkg.
module spr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  spr_pkg::desc_t wr_data,
    output logic           rd_valid,
    input  logic           rd_pop,
    output spr_pkg::desc_t rd_data
);

    spr_pkg::desc_t                mem_reg [spr_pkg::QDEPTH];
    logic [spr_pkg::QAW-1:0]       wr_ptr_reg;
    logic [spr_pkg::QAW-1:0]       rd_ptr_reg;
    logic [spr_pkg::QAW:0]         count_reg;
    logic [spr_pkg::QAW:0]         count_next;
    logic                          push;
    logic                          pop;

    assign wr_ready = (count_reg != (spr_pkg::QAW+1)'(spr_pkg::QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hw/rtl/spr_back.sv @@
`timescale 1ns / 1ps
// spr_back: expands queued descriptors into result items, one per cycle while
// m_ready allows, through a registered output stage. Depends on spr_pkg.
module spr_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  spr_pkg::cfg_t      cfg,
    input  logic               head_valid,
    input  spr_pkg::desc_t     head,
    output logic               head_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output spr_pkg::out_item_t m_item
);

    logic [3:0]         pos_reg;
    logic               m_valid_reg;
    spr_pkg::out_item_t m_item_reg;
    spr_pkg::out_item_t item_next;
    logic               load;
    logic               final_res;
    logic [3:0]         src_idx;

    assign load      = head_valid && (!m_valid_reg || m_ready);
    assign final_res = (({1'b0, pos_reg} + 5'd1) == head.num);
    assign head_pop  = load && final_res;
    assign src_idx   = head.start - pos_reg;

    always_comb begin
        item_next.run_last   = final_res;
        item_next.output_end = final_res && head.str_end;
        unique case (head.kind)
            spr_pkg::DESC_WIN: begin
                item_next.out_byte   = head.snap[src_idx];
                item_next.byte_valid = 1'b1;
            end
            spr_pkg::DESC_REPL: begin
                item_next.out_byte   = cfg.repl[pos_reg];
                item_next.byte_valid = 1'b1;
            end
            spr_pkg::DESC_EMPTY: begin
                item_next.out_byte   = 8'd0;
                item_next.byte_valid = 1'b0;
            end
            default: begin
                item_next.out_byte   = 8'd0;
                item_next.byte_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pos_reg     <= '0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                pos_reg     <= final_res ? 4'd0 : pos_reg + 4'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_item_reg <= item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

@@ hw/rtl/stream_pattern_replace_top.sv @@
`timescale 1ns / 1ps
// Stream search and replace, one byte per item. Every leftmost, non-overlapping
// occurrence of the programmed pattern (up to 16 bytes) is replaced by the
// programmed replacement (up to 16 bytes); other bytes pass in order, and the
// end of each string is marked on its last result (an empty marker item when
// nothing is left to send). Rate: an input item is taken every clock while the
// four-entry descriptor queue has room. Each item yields 0 to 16 results,
// which the back end sends one per clock while m_ready does not stall it, and
// the queue absorbs replacement bursts. The first result of an item passes
// through the descriptor queue and then the registered output stage. Program the
// registers only while the block is idle. Depends on spr_pkg, spr_cfg,
// spr_front, spr_queue and spr_back.
module stream_pattern_replace_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    // byte input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  spr_pkg::in_item_t           s_item,
    // edited string output channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output spr_pkg::out_item_t          m_item,
    // register port, 64-bit registers at 8-byte spacing
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spr_pkg::CFG_AW-1:0]  paddr,
    input  logic [spr_pkg::CFG_DW-1:0]  pwdata,
    output logic [spr_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);

    spr_pkg::cfg_t  cfg;
    spr_pkg::desc_t q_wr_data;
    spr_pkg::desc_t q_head;
    logic           q_wr_valid;
    logic           q_wr_ready;
    logic           q_valid;
    logic           q_pop;

    // Register bank; lengths above 16 are saturated here
    spr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Front end: window of pending bytes, match test against all prefix
    // lengths in parallel, at most one descriptor per item
    spr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .cfg        (cfg),
        .q_wr_valid (q_wr_valid),
        .q_wr_data  (q_wr_data),
        .q_wr_ready (q_wr_ready)
    );

    // Descriptor queue: lets the front keep taking bytes during bursts
    spr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_head)
    );

    // Back end: serialises each descriptor into result items
    spr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .head_valid (q_valid),
        .head       (q_head),
        .head_pop   (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

    // Input only stalls on a full queue, which cannot be empty at the same time
    a_stall_needs_queue : assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_valid
    ) else $error("input stalled while descriptor queue empty");

    // The empty marker only ever closes a string
    a_empty_marker : assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.byte_valid) |-> (m_item.run_last && m_item.output_end)
    ) else $error("empty result item without end marks");

    // End of string is always the last result of its item
    a_end_is_run_last : assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.output_end) |-> m_item.run_last
    ) else $error("output_end without run_last");

endmodule

@@ verif/stream_pattern_replace_top_test.sv @@
`timescale 1ns / 1ps
// stream_pattern_replace_top_test: self-checking bench for the stream search and replace
// block. Drives byte items and APB register writes, predicts the edited string per item.
// Depends on spr_pkg and stream_pattern_replace_top.
module stream_pattern_replace_top_test;
    import spr_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;  // far beyond the slowest correct run
    localparam int SETTLE_CYCLES = 32;      // covers items that leave no result behind
    localparam int PHASE_ITEMS   = 34;      // random items per register setting
    localparam int RANDOM_PHASES = 6;

    // Sixteen distinct bytes, used for the longest pattern
    localparam logic [63:0] LONG_PAT_LO = 64'h0123_4567_89AB_CDEF;
    localparam logic [63:0] LONG_PAT_HI = 64'hFEDC_BA98_7654_3210;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_item_t          s_item  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_item_t         m_item;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [CFG_AW-1:0] paddr   = '0;
    logic [CFG_DW-1:0] pwdata  = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    // Predictor copy of the registers and the pending-byte window
    logic [63:0] pat_lo      = '0;
    logic [63:0] pat_hi      = '0;
    logic [4:0]  pat_len_cfg = '0;
    logic [63:0] rep_lo      = '0;
    logic [63:0] rep_hi      = '0;
    logic [4:0]  rep_len_cfg = '0;
    logic [7:0]  win_buf [WIN_DEPTH];
    int          win_fill    = 0;
    int          run_len     = 0;

    in_item_t    pending_bytes [$];   // items waiting for the driver
    out_item_t   edited_q [$];        // edited string still to come, oldest first
    out_item_t   result_want;
    int          fail_count  = 0;
    int          cycle_count = 0;
    bit          byte_taken  = 1'b0;  // input item accepted at the last rising edge

    // Sender burst/gap state and receiver stall pattern
    int          burst_left  = 0;
    int          gap_left    = 0;
    logic        next_valid;
    in_item_t    next_item;
    int          stall_left  = 0;
    logic [7:0]  stall_pat   = 8'hFF;
    logic [2:0]  stall_pos   = '0;

    always #10 aclk = ~aclk;

    stream_pattern_replace_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Byte idx of a 16-byte string held as two 64-bit words, byte 0 lowest
    function automatic logic [7:0] byte_of(input logic [63:0] lo, input logic [63:0] hi,
                                           input int idx);
        return (idx < 8) ? lo[8*idx +: 8] : hi[8*(idx-8) +: 8];
    endfunction

    // First n window bytes equal the first n pattern bytes
    function automatic bit window_is_prefix(input int n);
        for (int i = 0; i < n; i++)
            if (win_buf[i] !== byte_of(pat_lo, pat_hi, i))
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic add_result(input logic [7:0] b, input logic carries_byte);
        out_item_t r;
        if (run_len < MAX_REPLACE) begin
            r            = '0;
            r.out_byte   = b;
            r.byte_valid = carries_byte;
            edited_q.push_back(r);
            run_len++;
        end
    endtask

    task automatic release_oldest();
        add_result(win_buf[0], 1'b1);
        for (int i = 0; i < WIN_DEPTH - 1; i++)
            win_buf[i] = win_buf[i+1];
        win_fill--;
    endtask

    // Expected results of one accepted byte item
    task automatic predict_edit(input in_item_t it);
        int        plen;
        int        rlen;
        out_item_t tail;
        plen    = (pat_len_cfg > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len_cfg);
        rlen    = (rep_len_cfg > MAX_REPLACE) ? MAX_REPLACE : int'(rep_len_cfg);
        run_len = 0;
        if (win_fill >= WIN_DEPTH)
            win_fill = WIN_DEPTH - 1;
        win_buf[win_fill] = it.data_byte;
        win_fill++;
        // Only a whole window equal to the pattern counts as a match; after a
        // pattern change mid-string the leftovers drain as plain bytes.
        if (plen > 0 && win_fill == plen && window_is_prefix(plen)) begin
            for (int i = 0; i < rlen; i++)
                add_result(byte_of(rep_lo, rep_hi, i), 1'b1);
            win_fill = 0;
        end else begin
            while (win_fill > 0 && !(win_fill < plen && window_is_prefix(win_fill)))
                release_oldest();
        end
        if (it.string_end) begin
            while (win_fill > 0)
                release_oldest();
            if (run_len == 0)
                add_result(8'h00, 1'b0);   // empty end marker
        end
        if (run_len > 0) begin
            tail            = edited_q.pop_back();
            tail.run_last   = 1'b1;
            tail.output_end = it.string_end;
            edited_q.push_back(tail);
        end
    endtask

    task automatic report_mismatch(input string what, input out_item_t got,
                                   input out_item_t want);
        fail_count++;
        $display("%0t: %s: got %02h v%0b l%0b e%0b, want %02h v%0b l%0b e%0b", $time, what,
                 got.out_byte, got.byte_valid, got.run_last, got.output_end,
                 want.out_byte, want.byte_valid, want.run_last, want.output_end);
    endtask

    // ------------------------------------------------------------------
    // Monitor: everything sampled at the rising edge. Results are checked
    // before the item accepted at the same edge is predicted, since its
    // first result cannot appear before the next edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timed out with %0d results outstanding", edited_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else if (aresetn) begin
            byte_taken = s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (edited_q.size() == 0) begin
                    report_mismatch("result with none expected", m_item, '0);
                end else begin
                    result_want = edited_q.pop_front();
                    if (m_item.out_byte !== result_want.out_byte)
                        report_mismatch("out_byte", m_item, result_want);
                    if (m_item.byte_valid !== result_want.byte_valid)
                        report_mismatch("byte_valid", m_item, result_want);
                    if (m_item.run_last !== result_want.run_last)
                        report_mismatch("run_last", m_item, result_want);
                    if (m_item.output_end !== result_want.output_end)
                        report_mismatch("output_end", m_item, result_want);
                end
            end
            if (byte_taken)
                predict_edit(s_item);
            // Register copy follows the bus, so it changes at the write edge
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[CFG_AW-1:3]))
                    REG_PATTERN_LOW:  pat_lo      = pwdata;
                    REG_PATTERN_HIGH: pat_hi      = pwdata;
                    REG_PATTERN_LEN:  pat_len_cfg = pwdata[4:0];
                    REG_REPLACE_LOW:  rep_lo      = pwdata;
                    REG_REPLACE_HIGH: rep_hi      = pwdata;
                    REG_REPLACE_LEN:  rep_len_cfg = pwdata[4:0];
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte driver: bursts of random length with random gaps in between;
    // valid holds with a steady item until the handshake.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        next_valid = s_valid && !byte_taken;
        next_item  = s_item;
        if (!next_valid && aresetn) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_bytes.size() > 0) begin
                next_item  = pending_bytes.pop_front();
                next_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        s_valid <= next_valid;
        s_item  <= next_item;
    end

    // Receiver: a rotating 8-bit ready pattern, replaced now and then;
    // all-ones gives stretches with no stall at all.
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(16, 128);
            stall_pat  = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
        end
        stall_left--;
        stall_pos++;
        m_ready <= stall_pat[stall_pos];
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void queue_byte(input logic [7:0] b, input bit closes);
        in_item_t it;
        it.data_byte  = b;
        it.string_end = closes;
        pending_bytes.push_back(it);
    endfunction

    task automatic queue_text(input string txt, input bit closes);
        for (int i = 0; i < txt.len(); i++)
            queue_byte(txt[i], closes && i == txt.len() - 1);
    endtask

    // Setup cycle then access cycle; the write lands where pready is seen high
    task automatic write_register(input reg_idx_t idx, input logic [63:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_block(input logic [63:0] plo, input logic [63:0] phi,
                                 input logic [63:0] plen, input logic [63:0] rlo,
                                 input logic [63:0] rhi, input logic [63:0] rlen);
        write_register(REG_PATTERN_LOW,  plo);
        write_register(REG_PATTERN_HIGH, phi);
        write_register(REG_PATTERN_LEN,  plen);
        write_register(REG_REPLACE_LOW,  rlo);
        write_register(REG_REPLACE_HIGH, rhi);
        write_register(REG_REPLACE_LEN,  rlen);
    endtask

    // Sender holds off until every item is in and every result is out,
    // then allows time for items that produce nothing.
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || s_valid || edited_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register setting, then strings built mostly from pattern pieces
    // (whole copies, prefixes, pattern-alphabet bytes) with some noise.
    // Odd phases but the last leave their final string open across the rewrite.
    task automatic run_random_phase(input int phase);
        logic [7:0]  alphabet [3];
        logic [63:0] plo;
        logic [63:0] phi;
        logic [63:0] rlo;
        logic [63:0] rhi;
        logic [4:0]  plen;
        logic [4:0]  rlen;
        logic [7:0]  text [$];
        int          span;
        int          fed;
        int          cut;
        bit          closes;
        for (int i = 0; i < 3; i++)
            alphabet[i] = 8'($urandom);
        plo = {$urandom, $urandom};
        phi = {$urandom, $urandom};
        for (int i = 0; i < 8; i++) begin
            if ($urandom_range(0, 3) != 0)
                plo[8*i +: 8] = alphabet[$urandom_range(0, 2)];
            if ($urandom_range(0, 3) != 0)
                phi[8*i +: 8] = alphabet[$urandom_range(0, 2)];
        end
        rlo = {$urandom, $urandom};
        rhi = {$urandom, $urandom};
        case (phase)
            0: begin
                plen = 5'd1;
                rlen = 5'd16;
            end
            1: begin
                plen = 5'd16;
                rlen = 5'd0;
            end
            2: begin   // both lengths oversized, clamp to 16
                plen = 5'($urandom_range(17, 31));
                rlen = 5'($urandom_range(17, 31));
            end
            default: begin
                plen = 5'($urandom_range(2, 6));
                rlen = 5'($urandom_range(0, 16));
            end
        endcase
        program_block(plo, phi, 64'(plen), rlo, rhi, 64'(rlen));
        span = (plen > MAX_PATTERN) ? MAX_PATTERN : int'(plen);
        fed  = 0;
        while (fed < PHASE_ITEMS) begin
            text.delete();
            repeat ($urandom_range(1, 5)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        for (int i = 0; i < span; i++)
                            text.push_back(byte_of(plo, phi, i));
                    end
                    4, 5: begin
                        cut = $urandom_range(0, span);
                        for (int i = 0; i < cut; i++)
                            text.push_back(byte_of(plo, phi, i));
                    end
                    6, 7: text.push_back(alphabet[$urandom_range(0, 2)]);
                    default: text.push_back(8'($urandom));
                endcase
            end
            if (text.size() == 0)
                text.push_back(8'($urandom));
            for (int i = 0; i < text.size() && fed < PHASE_ITEMS; i++) begin
                closes = (i == text.size() - 1);
                if (fed == PHASE_ITEMS - 1)
                    closes = (phase % 2 == 0) || (phase == RANDOM_PHASES - 1);
                queue_byte(text[i], closes);
                fed++;
            end
        end
        wait_idle();
    endtask

    initial begin
        // Synchronous reset, released on a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Pattern length zero after reset: plain pass-through, data extremes
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        wait_idle();

        // "ab" -> "XYZ": a stray leading byte, then a match closing the string
        program_block(64'h6261, '0, 64'd2, 64'h5A_5958, '0, 64'd3);
        queue_text("aab", 1'b1);
        wait_idle();

        // Longest pattern and replacement, lengths written as all ones
        program_block(LONG_PAT_LO, LONG_PAT_HI, '1, '1, '0, '1);
        for (int i = 0; i < MAX_PATTERN; i++)
            queue_byte(byte_of(LONG_PAT_LO, LONG_PAT_HI, i), i == MAX_PATTERN - 1);
        wait_idle();

        // Deletion: string ends on a match, so only the empty end marker comes
        write_register(REG_PATTERN_LOW, 64'h6261);
        write_register(REG_PATTERN_LEN, 64'd2);
        write_register(REG_REPLACE_LEN, 64'd0);
        queue_text("ab", 1'b1);
        wait_idle();

        // Pattern swapped mid-string: "abc" held against "abcd", then "cd" takes
        // over; the trailing "cd" must leave as plain bytes
        write_register(REG_PATTERN_LOW, 64'h6463_6261);
        write_register(REG_PATTERN_LEN, 64'd4);
        queue_text("abc", 1'b0);
        wait_idle();
        write_register(REG_PATTERN_LOW, 64'h6463);
        write_register(REG_PATTERN_LEN, 64'd2);
        queue_text("d", 1'b1);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
            run_random_phase(p);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
